// ----- hw/rtl/cbie_pkg.sv -----
// ----------------------------------------------------------------------------
// cbie_pkg
// Shared types and constants for the CBOR item head encoder.
// ----------------------------------------------------------------------------
package cbie_pkg;

	localparam int QDepth = 2;
	localparam int QPtrW  = 1;
	localparam int QCntW  = 2;

	localparam logic [3:0] OP_UINT  = 4'd0;
	localparam logic [3:0] OP_INT32 = 4'd1;
	localparam logic [3:0] OP_ARRAY = 4'd2;
	localparam logic [3:0] OP_MAP   = 4'd3;
	localparam logic [3:0] OP_TEXT  = 4'd4;
	localparam logic [3:0] OP_BYTES = 4'd5;
	localparam logic [3:0] OP_BOOL  = 4'd6;
	localparam logic [3:0] OP_HALF  = 4'd7;
	localparam logic [3:0] OP_F32   = 4'd8;
	localparam logic [3:0] OP_F64   = 4'd9;

	localparam logic [7:0] MT_UINT  = 8'h00;
	localparam logic [7:0] MT_NINT  = 8'h20;
	localparam logic [7:0] MT_BYTES = 8'h40;
	localparam logic [7:0] MT_TEXT  = 8'h60;
	localparam logic [7:0] MT_ARRAY = 8'h80;
	localparam logic [7:0] MT_MAP   = 8'hA0;

	localparam logic [7:0] HD_FALSE = 8'hF4;
	localparam logic [7:0] HD_HALF  = 8'hF9;
	localparam logic [7:0] HD_F32   = 8'hFA;
	localparam logic [7:0] HD_F64   = 8'hFB;

	localparam logic [7:0] AI_ONE   = 8'd24;
	localparam logic [7:0] AI_TWO   = 8'd25;
	localparam logic [7:0] AI_FOUR  = 8'd26;
	localparam logic [7:0] AI_EIGHT = 8'd27;

	localparam logic [7:0] HalfBias = 8'd112;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [63:0] value;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} rsp_t;

	// data is left-aligned: first following byte sits in bits 63:56
	typedef struct packed {
		logic [7:0]  head;
		logic [63:0] data;
		logic [3:0]  nbytes;
	} cmd_t;

endpackage

// ----- hw/rtl/cbie_front.sv -----
// ----------------------------------------------------------------------------
// cbie_front
// Accepts items, classifies the opcode and builds head byte, aligned data and
// following byte count into a registered command.
// ----------------------------------------------------------------------------
module cbie_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  cbie_pkg::req_t      req,
	output logic                push,
	output cbie_pkg::cmd_t      push_cmd,
	input  logic                q_full
);

	logic           v_s1;
	cbie_pkg::cmd_t cmd_s1;
	cbie_pkg::cmd_t cmd_c;
	logic [7:0]     major;
	logic [63:0]    uval;
	logic           use_uint;
	logic [31:0]    lo;
	logic [7:0]     ex8;
	logic [7:0]     ex_diff;
	logic [4:0]     ex5;
	logic [15:0]    half;
	logic [7:0]     hd;
	logic [63:0]    raw;
	logic [3:0]     nb;

	assign lo      = req.value[31:0];
	assign ex8     = lo[30:23];
	assign ex_diff = ex8 - cbie_pkg::HalfBias;
	assign ex5     = (ex8 != 8'd0) ? ex_diff[4:0] : 5'd0;
	assign half    = {lo[31], ex5, lo[22:13]};

	always_comb begin
		major    = cbie_pkg::MT_UINT;
		uval     = req.value;
		use_uint = 1'b1;
		hd       = cbie_pkg::HD_FALSE;
		raw      = 64'd0;
		nb       = 4'd0;
		case (req.opcode)
			cbie_pkg::OP_INT32: begin
				if (lo[31]) begin
					major = cbie_pkg::MT_NINT;
					uval  = {32'd0, ~lo};
				end else begin
					uval  = {32'd0, lo};
				end
			end
			cbie_pkg::OP_ARRAY: major = cbie_pkg::MT_ARRAY;
			cbie_pkg::OP_MAP:   major = cbie_pkg::MT_MAP;
			cbie_pkg::OP_TEXT:  major = cbie_pkg::MT_TEXT;
			cbie_pkg::OP_BYTES: major = cbie_pkg::MT_BYTES;
			cbie_pkg::OP_BOOL: begin
				use_uint = 1'b0;
				hd       = cbie_pkg::HD_FALSE | {7'd0, req.value[0]};
			end
			cbie_pkg::OP_HALF: begin
				use_uint = 1'b0;
				hd       = cbie_pkg::HD_HALF;
				raw      = {48'd0, half};
				nb       = 4'd2;
			end
			cbie_pkg::OP_F32: begin
				use_uint = 1'b0;
				hd       = cbie_pkg::HD_F32;
				raw      = {32'd0, lo};
				nb       = 4'd4;
			end
			cbie_pkg::OP_F64: begin
				use_uint = 1'b0;
				hd       = cbie_pkg::HD_F64;
				raw      = req.value;
				nb       = 4'd8;
			end
			default: major = cbie_pkg::MT_UINT;
		endcase

		if (use_uint) begin
			raw = uval;
			if (uval < 64'd24) begin
				hd = major | {3'd0, uval[4:0]};
				nb = 4'd0;
			end else if (uval <= 64'hFF) begin
				hd = major | cbie_pkg::AI_ONE;
				nb = 4'd1;
			end else if (uval <= 64'hFFFF) begin
				hd = major | cbie_pkg::AI_TWO;
				nb = 4'd2;
			end else if (uval <= 64'hFFFF_FFFF) begin
				hd = major | cbie_pkg::AI_FOUR;
				nb = 4'd4;
			end else begin
				hd = major | cbie_pkg::AI_EIGHT;
				nb = 4'd8;
			end
		end

		cmd_c.head   = hd;
		cmd_c.nbytes = nb;
		case (nb)
			4'd1:    cmd_c.data = raw << 56;
			4'd2:    cmd_c.data = raw << 48;
			4'd4:    cmd_c.data = raw << 32;
			default: cmd_c.data = raw;
		endcase
	end

	assign req_stall = v_s1 & q_full;
	assign push      = v_s1 & ~q_full;
	assign push_cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!req_stall) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			cmd_s1 <= cmd_c;
		end
	end

endmodule

// ----- hw/rtl/cbie_queue.sv -----
// ----------------------------------------------------------------------------
// cbie_queue
// Short command queue between classifier and byte emitter.
// ----------------------------------------------------------------------------
module cbie_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cbie_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output cbie_pkg::cmd_t head_cmd
);

	cbie_pkg::cmd_t                mem_q [cbie_pkg::QDepth];
	logic [cbie_pkg::QPtrW-1:0]    wr_q;
	logic [cbie_pkg::QPtrW-1:0]    rd_q;
	logic [cbie_pkg::QCntW-1:0]    cnt_q;

	assign full     = (cnt_q == cbie_pkg::QCntW'(cbie_pkg::QDepth));
	assign q_valid  = (cnt_q != '0);
	assign head_cmd = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cbie_pkg::QCntW'(cbie_pkg::QDepth))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> !pop)
		else $error("pop from empty queue");

endmodule

// ----- hw/rtl/cbie_back.sv -----
// ----------------------------------------------------------------------------
// cbie_back
// Byte emitter: sends the head byte, then the following bytes, one per cycle
// while rsp_stall is low, through an output register.
// ----------------------------------------------------------------------------
module cbie_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  cbie_pkg::cmd_t head_cmd,
	output logic           pop,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cbie_pkg::rsp_t rsp
);

	logic        out_valid_q;
	logic        busy_q;
	logic [3:0]  rem_q;
	logic [63:0] sh_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        step;

	assign step      = ~out_valid_q | ~rsp_stall;
	assign pop       = step & ~busy_q & q_valid;
	assign rsp_valid = out_valid_q;
	assign rsp       = '{out_byte: byte_q, last_byte: last_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			rem_q       <= 4'd0;
			last_q      <= 1'b0;
		end else if (step) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				last_q      <= (rem_q == 4'd1);
				busy_q      <= (rem_q != 4'd1);
				rem_q       <= rem_q - 4'd1;
			end else if (q_valid) begin
				out_valid_q <= 1'b1;
				last_q      <= (head_cmd.nbytes == 4'd0);
				busy_q      <= (head_cmd.nbytes != 4'd0);
				rem_q       <= head_cmd.nbytes;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (busy_q) begin
				byte_q <= sh_q[63:56];
				sh_q   <= sh_q << 8;
			end else if (q_valid) begin
				byte_q <= head_cmd.head;
				sh_q   <= head_cmd.data;
			end
		end
	end

	a_busy_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q != 4'd0))
		else $error("emitter busy with no bytes left");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> !busy_q)
		else $error("last byte shown while bytes remain");

endmodule

// ----- hw/rtl/cbor_item_head_encoder.sv -----
// ----------------------------------------------------------------------------
// cbor_item_head_encoder
// Top level: CBOR data item head encoder, opcode and value in, head bytes out.
// ----------------------------------------------------------------------------
// Each item yields 1 to 9 bytes on rsp, most significant first, with
// last_byte set on the final one. The byte-wide output register sets the
// rate: an item occupies the output for its head byte and n following
// bytes (n = 0, 1, 2, 4 or 8); with the next item queued and rsp_stall
// low, its head byte follows the last byte in the very next cycle. An
// item passes the classify register, loaded at the accepting edge, then
// the two-entry queue and the output register. Inputs keep being taken
// until the queue is full and the classify register holds an item.
module cbor_item_head_encoder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cbie_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cbie_pkg::rsp_t rsp
);

	logic           push;
	logic           full;
	logic           pop;
	logic           q_valid;
	cbie_pkg::cmd_t push_cmd;
	cbie_pkg::cmd_t head_cmd;

	cbie_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (full)
	);

	cbie_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.q_valid  (q_valid),
		.head_cmd (head_cmd)
	);

	cbie_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
